FILE: src/sspq_pkg.sv
// Package for the stable sorted priority queue: field widths, beat layouts,
// status codes and default parameter values. It depends on nothing.
`default_nettype none

package sspq_pkg;

    localparam int CAPACITY_DEF      = 16;
    localparam int PRIORITY_BITS_DEF = 8;

    localparam int VALUE_W    = 32;
    localparam int FIELD_PRI_W = 8;
    localparam int OCC_W      = 5;
    localparam int STATUS_W   = 2;

    // Slave beat: in_value, in_priority, zero padding to whole bytes.
    localparam int S_TDATA_W  = 48;
    localparam int S_PAD_W    = S_TDATA_W - VALUE_W - FIELD_PRI_W;
    // Master beat: out_value, out_priority, occupancy, zero padding.
    localparam int M_TDATA_W  = 48;
    localparam int M_PAD_W    = M_TDATA_W - VALUE_W - FIELD_PRI_W - OCC_W;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

endpackage : sspq_pkg

`default_nettype wire

FILE: src/stable_sorted_priority_queue.sv
// Stable sorted priority queue. A remove reads the head slot and loads it as its result; a
// remove from empty or an insert into a full queue goes straight to its result. An insert
// shifts larger-priority entries up a slot from the tail down and puts the new entry in the gap.
// One beat is in work at a time: the next is taken once its result is loaded, and a result held
// by the receiver stalls the input. Reset (aresetn low, synchronous) empties the queue; the
// slot memory is not cleared, as only slots holding entries are ever read. Uses sspq_pkg.
`default_nettype none

module stable_sorted_priority_queue
    import sspq_pkg::*;
#(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [31:0] in_value, [39:32] in_priority, [47:40] zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [0] mode
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [31:0] out_value, [39:32] out_priority, [44:40] occupancy, [47:45] zero
    output logic [M_TDATA_W-1:0]      m_tdata,
    // [1:0] status
    output logic [STATUS_W-1:0]       m_tuser
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INS_RD  = 3'd1;
    localparam logic [2:0] S_INS_CMP = 3'd2;
    localparam logic [2:0] S_INS_PUT = 3'd3;
    localparam logic [2:0] S_REM_RD  = 3'd4;
    localparam logic [2:0] S_REM_OUT = 3'd5;
    localparam logic [2:0] S_RESP    = 3'd6;

    function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
        ptr_inc = (p == IDX_W'(CAPACITY - 1)) ? '0 : p + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] ptr_dec(input logic [IDX_W-1:0] p);
        ptr_dec = (p == '0) ? IDX_W'(CAPACITY - 1) : p - IDX_W'(1);
    endfunction

    // Slot memory, kept as a circular buffer so that a remove moves nothing.
    logic [VALUE_W-1:0]       val_mem [CAPACITY];
    logic [PRIORITY_BITS-1:0] pri_mem [CAPACITY];

    logic [2:0]               state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [IDX_W-1:0]         head_reg, head_next;
    logic [IDX_W-1:0]         tail_reg, tail_next;
    logic [IDX_W-1:0]         scan_reg, scan_next;   // slot being compared
    logic [IDX_W-1:0]         hole_reg, hole_next;   // free slot above it
    logic [VALUE_W-1:0]       new_val_reg, new_val_next;
    logic [PRIORITY_BITS-1:0] new_pri_reg, new_pri_next;
    logic [VALUE_W-1:0]       res_val_reg, res_val_next;
    logic [PRIORITY_BITS-1:0] res_pri_reg, res_pri_next;
    logic [STATUS_W-1:0]      res_st_reg, res_st_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]     m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0]      m_tuser_reg, m_tuser_next;

    logic [VALUE_W-1:0]       rd_val_reg;
    logic [PRIORITY_BITS-1:0] rd_pri_reg;
    logic [IDX_W-1:0]         rd_addr;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic [VALUE_W-1:0]       wr_val;
    logic [PRIORITY_BITS-1:0] wr_pri;

    logic                     s_fire;
    logic                     out_free;
    logic                     moves_up;
    logic [PRIORITY_BITS+FIELD_PRI_W-1:0] in_pri_ext;
    logic [PRIORITY_BITS+FIELD_PRI_W-1:0] out_pri_ext;
    logic [OCC_W+CNT_W-1:0]   occ_ext;

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign in_pri_ext  = {{PRIORITY_BITS{1'b0}}, s_tdata[VALUE_W +: FIELD_PRI_W]};
    assign out_pri_ext = {{FIELD_PRI_W{1'b0}}, res_pri_reg};
    assign occ_ext     = {{OCC_W{1'b0}}, count_reg};

    // The one comparator: does the stored entry sort after the new one?
    assign moves_up = (rd_pri_reg > new_pri_reg);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        scan_next     = scan_reg;
        hole_next     = hole_reg;
        new_val_next  = new_val_reg;
        new_pri_next  = new_pri_reg;
        res_val_next  = res_val_reg;
        res_pri_next  = res_pri_reg;
        res_st_next   = res_st_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        rd_addr       = scan_reg;
        wr_en         = 1'b0;
        wr_addr       = hole_reg;
        wr_val        = new_val_reg;
        wr_pri        = new_pri_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    new_val_next = s_tdata[VALUE_W-1:0];
                    new_pri_next = in_pri_ext[PRIORITY_BITS-1:0];
                    res_val_next = '0;
                    res_pri_next = '0;
                    if (s_tuser == MODE_REMOVE) begin
                        if (count_reg == '0) begin
                            res_st_next = ST_EMPTY;
                            state_next  = S_RESP;
                        end else begin
                            state_next  = S_REM_RD;
                        end
                    end else if (count_reg == CNT_W'(CAPACITY)) begin
                        res_st_next = ST_FULL;
                        state_next  = S_RESP;
                    end else if (count_reg == '0) begin
                        state_next  = S_INS_PUT;
                    end else begin
                        scan_next   = ptr_dec(tail_reg);
                        hole_next   = tail_reg;
                        state_next  = S_INS_RD;
                    end
                end
            end
            S_INS_RD: begin
                rd_addr    = scan_reg;
                state_next = S_INS_CMP;
            end
            S_INS_CMP: begin
                wr_en   = 1'b1;
                wr_addr = hole_reg;
                if (moves_up) begin
                    // Shift the larger entry up one slot and look further down.
                    wr_val = rd_val_reg;
                    wr_pri = rd_pri_reg;
                    if (scan_reg == head_reg) begin
                        state_next = S_INS_PUT;
                    end else begin
                        hole_next  = scan_reg;
                        scan_next  = ptr_dec(scan_reg);
                        state_next = S_INS_RD;
                    end
                end else begin
                    count_next  = count_reg + CNT_W'(1);
                    tail_next   = ptr_inc(tail_reg);
                    res_st_next = ST_INSERTED;
                    state_next  = S_RESP;
                end
            end
            S_INS_PUT: begin
                // The new entry becomes the head.
                wr_en       = 1'b1;
                wr_addr     = head_reg;
                count_next  = count_reg + CNT_W'(1);
                tail_next   = ptr_inc(tail_reg);
                res_st_next = ST_INSERTED;
                state_next  = S_RESP;
            end
            S_REM_RD: begin
                rd_addr    = head_reg;
                state_next = S_REM_OUT;
            end
            S_REM_OUT: begin
                res_val_next = rd_val_reg;
                res_pri_next = rd_pri_reg;
                res_st_next  = ST_REMOVED;
                head_next    = ptr_inc(head_reg);
                count_next   = count_reg - CNT_W'(1);
                state_next   = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{M_PAD_W{1'b0}}, occ_ext[OCC_W-1:0],
                                     out_pri_ext[FIELD_PRI_W-1:0], res_val_reg};
                    m_tuser_next  = res_st_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            val_mem[wr_addr] <= wr_val;
            pri_mem[wr_addr] <= wr_pri;
        end
        rd_val_reg <= val_mem[rd_addr];
        rd_pri_reg <= pri_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg    <= scan_next;
        hole_reg    <= hole_next;
        new_val_reg <= new_val_next;
        new_pri_reg <= new_pri_next;
        res_val_reg <= res_val_next;
        res_pri_reg <= res_pri_next;
        res_st_reg  <= res_st_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // Tail must always sit count slots past the head, modulo the capacity.
    logic [CNT_W:0] tail_sum;
    logic [CNT_W:0] tail_calc;
    assign tail_sum  = (CNT_W+1)'(head_reg) + (CNT_W+1)'(count_reg);
    assign tail_calc = (tail_sum >= (CNT_W+1)'(CAPACITY)) ?
                       tail_sum - (CNT_W+1)'(CAPACITY) : tail_sum;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_ptr_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        tail_calc == (CNT_W+1)'(tail_reg))
        else $error("head, tail and count disagree");

    a_resp_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESP) && !m_tvalid_reg |=> m_tvalid_reg && (state_reg == S_IDLE))
        else $error("result not loaded into a free output register");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg != S_IDLE))
        else $error("accepted beat started no work");

endmodule : stable_sorted_priority_queue

`default_nettype wire

FILE: sim/sspq_checker.sv
// Checker for the stable sorted priority queue: watches both stream channels, keeps its
// own copy of the sorted slots and compares every reply beat with the predicted one.
// Depends on sspq_pkg.
module sspq_checker
    import sspq_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    // [31:0] in_value, [39:32] in_priority, [47:40] zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [0] mode
    input  wire logic                 s_tuser,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    // [31:0] out_value, [39:32] out_priority, [44:40] occupancy, [47:45] zero
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    // [1:0] status
    input  wire logic [STATUS_W-1:0]  m_tuser,
    output int                        fail_count,
    output int                        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRI_LSB = VALUE_W;
    localparam int OCC_LSB = VALUE_W + FIELD_PRI_W;
    localparam int PAD_LSB = OCC_LSB + OCC_W;

    typedef struct packed {
        logic [VALUE_W-1:0]     value;
        logic [FIELD_PRI_W-1:0] prio;
        logic [STATUS_W-1:0]    status;
        logic [OCC_W-1:0]       occ;
    } reply_t;

    logic [VALUE_W-1:0]     slot_val [CAPACITY_DEF];
    logic [FIELD_PRI_W-1:0] slot_pri [CAPACITY_DEF];
    int                     stored;
    reply_t                 replies_due [$];

    // Applies one insert or remove to the slot copy and returns the reply it gives.
    function automatic reply_t apply_queue_op(input logic op, input logic [VALUE_W-1:0] v,
                                              input logic [FIELD_PRI_W-1:0] p);
        reply_t r;
        int     pos;
        r = '0;
        if (op == MODE_INSERT) begin
            if (stored >= CAPACITY_DEF) begin
                r.status = ST_FULL;
            end else begin
                // The new entry goes behind every entry of equal priority.
                pos = 0;
                while (pos < stored && slot_pri[pos] <= p)
                    pos++;
                for (int i = stored; i > pos; i--) begin
                    slot_val[i] = slot_val[i-1];
                    slot_pri[i] = slot_pri[i-1];
                end
                slot_val[pos] = v;
                slot_pri[pos] = p;
                stored++;
                r.status = ST_INSERTED;
            end
        end else if (stored == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.value = slot_val[0];
            r.prio  = slot_pri[0];
            for (int i = 1; i < stored; i++) begin
                slot_val[i-1] = slot_val[i];
                slot_pri[i-1] = slot_pri[i];
            end
            stored--;
            r.status = ST_REMOVED;
        end
        r.occ = stored[OCC_W-1:0];
        return r;
    endfunction

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
            fail_count++;
        end
    endtask

    // Reply beats are checked before the request beat of the same edge is predicted;
    // a request can never be answered on the edge that accepts it.
    always @(posedge aclk) begin
        reply_t want;
        if (!aresetn) begin
            stored = 0;
            replies_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (replies_due.size() == 0) begin
                    $display("%0t: reply beat with none due, expected nothing, actual 0x%0h",
                             $time, m_tdata);
                    fail_count++;
                end else begin
                    want = replies_due.pop_front();
                    compare_field("out_value", want.value, m_tdata[PRI_LSB-1:0]);
                    compare_field("out_priority", 32'(want.prio),
                                  32'(m_tdata[OCC_LSB-1:PRI_LSB]));
                    compare_field("occupancy", 32'(want.occ),
                                  32'(m_tdata[PAD_LSB-1:OCC_LSB]));
                    compare_field("tdata padding", '0, 32'(m_tdata[M_TDATA_W-1:PAD_LSB]));
                    compare_field("status", 32'(want.status), 32'(m_tuser));
                end
            end
            if (s_tvalid && s_tready)
                replies_due.push_back(apply_queue_op(s_tuser, s_tdata[PRI_LSB-1:0],
                                                     s_tdata[OCC_LSB-1:PRI_LSB]));
        end
        outstanding <= replies_due.size();
    end

endmodule

FILE: sim/stable_sorted_priority_queue_tb.sv
// Testbench top for the stable sorted priority queue: drives insert and remove beats,
// shapes the reply-side back-pressure and gives the verdict from the checker's count.
// Depends on sspq_pkg, stable_sorted_priority_queue and sspq_checker.
module stable_sorted_priority_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sspq_pkg::*;

    localparam int RUN_LIMIT    = 500000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_TAIL   = 40;
    localparam int RANDOM_ITEMS = 524;
    localparam int PHASES       = 4;
    localparam int SEND_IDLE [PHASES] = '{0, 56, 0, 14};
    localparam int RECV_STALL[PHASES] = '{0, 0, 56, 14};

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = MODE_INSERT;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    logic hold_req   = 1'b0;
    int   hold_left  = 0;
    int   idle_pct   = 0;
    int   stall_pct  = 0;
    int   cycle_count = 0;
    int   fail_count;
    int   outstanding;

    stable_sorted_priority_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    sspq_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Reply side: random stalls, or a long hold-off once requested.
    always @(posedge aclk) begin
        if (hold_req)
            hold_left = HOLD_CYCLES;
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offers one beat and returns at the edge that accepts it, leaving tvalid high.
    task automatic send_op(input logic op, input logic [VALUE_W-1:0] v,
                           input logic [FIELD_PRI_W-1:0] p);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{S_PAD_W{1'b0}}, p, v};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
    endtask

    initial begin
        logic                   op;
        logic [FIELD_PRI_W-1:0] p;
        int                     burst_left;
        int                     insert_pct;
        int                     pri_shape;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: remove from empty, fill with ties and extremes, insert into a full
        // queue, then take a few heads off. Removes carry junk that must be ignored.
        send_op(MODE_REMOVE, 32'h1234_5678, 8'hAB);
        send_op(MODE_INSERT, 32'h7FFF_FFFF, 8'd255);
        send_op(MODE_INSERT, 32'h8000_0000, 8'd0);
        send_op(MODE_INSERT, 32'd1, 8'd5);
        send_op(MODE_INSERT, 32'd2, 8'd5);
        send_op(MODE_INSERT, 32'd3, 8'd5);
        send_op(MODE_INSERT, 32'hFFFF_FFFF, 8'd128);
        send_op(MODE_INSERT, 32'd0, 8'd1);
        send_op(MODE_INSERT, 32'd4, 8'd5);
        send_op(MODE_INSERT, 32'd5, 8'd254);
        send_op(MODE_INSERT, 32'd6, 8'd0);
        send_op(MODE_INSERT, 32'd7, 8'd255);
        send_op(MODE_INSERT, 32'd8, 8'd1);
        send_op(MODE_INSERT, 32'd9, 8'd128);
        send_op(MODE_INSERT, 32'd10, 8'd64);
        send_op(MODE_INSERT, 32'd11, 8'd5);
        send_op(MODE_INSERT, 32'd12, 8'd200);
        send_op(MODE_INSERT, 32'hDEAD_BEEF, 8'd0);
        repeat (7)
            send_op(MODE_REMOVE, $urandom, 8'($urandom));

        burst_left = 0;
        insert_pct = 50;
        pri_shape  = 0;
        for (int ph = 0; ph < PHASES; ph++) begin
            idle_pct  = SEND_IDLE[ph];
            stall_pct = RECV_STALL[ph];
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                // A single long reply hold-off while requests keep coming.
                hold_req <= (ph == 0 && n == 40);
                if (burst_left == 0) begin
                    burst_left = $urandom_range(40, 8);
                    case ($urandom_range(2))
                        0:       insert_pct = 85;
                        1:       insert_pct = 50;
                        default: insert_pct = 20;
                    endcase
                    pri_shape = $urandom_range(2);
                end
                burst_left--;
                op = ($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_REMOVE;
                case (pri_shape)
                    0:       p = 8'($urandom_range(3));
                    1:       p = 8'($urandom);
                    default: p = $urandom_range(1) ? 8'hFF : 8'h00;
                endcase
                send_op(op, $urandom, p);
            end
            wait_drained();
        end

        repeat (DRAIN_TAIL) @(posedge aclk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
